/* hw/rtl/mgkp_pkg.sv */
// Package: shared constants and types for the max GCD K-partition block.
`default_nettype none
package mgkp_pkg;
	localparam int MAX_LEN_DEF   = 1024;
	localparam int ELEM_BITS_DEF = 16;
	localparam int TOT_W         = 26;
	localparam int K_W           = 11;
	localparam int CNT_W         = 11;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_DIVI,
		ST_DIVI_WAIT,
		ST_CHK,
		ST_CNT_RD,
		ST_CNT_DIV,
		ST_CNT_WAIT,
		ST_CNT_ACC,
		ST_NEXT,
		ST_DONE
	} st_t;
endpackage
`default_nettype wire

/* hw/rtl/mgkp_ram.sv */
// Generic single-port RAM with registered read.
`default_nettype none
module mgkp_ram #(
	parameter int WIDTH = 26,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

/* hw/rtl/mgkp_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none
module mgkp_div
	import mgkp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             go,
	input  wire logic [TOT_W-1:0] dividend,
	input  wire logic [TOT_W-1:0] divisor,
	output logic                  done,
	output logic [TOT_W-1:0]      quot,
	output logic [TOT_W-1:0]      rem
);
	localparam int BC_W = $clog2(TOT_W + 1);
	logic [TOT_W-1:0] dvs_q;
	logic [TOT_W-1:0] shf_q;
	logic [TOT_W:0]   rem_q;
	logic [BC_W-1:0]  bits_q;
	logic             run_q;
	logic [TOT_W:0]   trial;

	assign trial = {rem_q[TOT_W-1:0], shf_q[TOT_W-1]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			bits_q <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q  <= 1'b1;
				bits_q <= BC_W'(TOT_W);
			end else if (run_q) begin
				bits_q <= bits_q - 1'b1;
				if (bits_q == BC_W'(1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			dvs_q <= divisor;
			shf_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			if (!trial[TOT_W]) begin
				rem_q <= trial;
				shf_q <= {shf_q[TOT_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[TOT_W-1:0], shf_q[TOT_W-1]};
				shf_q <= {shf_q[TOT_W-2:0], 1'b0};
			end
		end
	end

	assign quot = shf_q;
	assign rem  = rem_q[TOT_W-1:0];
endmodule
`default_nettype wire

/* hw/rtl/max_gcd_k_partition_top.sv */
// Top level: loads elements, then searches divisors of the total for the best GCD.
//
// Elements load at one per cycle while busy is low. After the element marked last,
// busy rises while the divisor search runs: for each candidate i from 1 to
// sqrt(total), one divide of the total, then for each candidate divisor a scan
// of every stored prefix sum through the same bit-serial divider, one divide per
// stored element. The result appears for one cycle on done and cannot be
// stalled. No clearing pass runs after reset.
`default_nettype none
module max_gcd_k_partition_top
	import mgkp_pkg::*;
#(
	parameter int MAX_LEN   = MAX_LEN_DEF,
	parameter int ELEM_BITS = ELEM_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [ELEM_BITS-1:0] element,
	input  wire logic                 last_element,
	input  wire logic                 cfg_we,
	input  wire logic [K_W-1:0]       cfg_wdata,
	output logic                      done,
	output logic [TOT_W-1:0]          best_divisor,
	output logic                      overflowed
);
	localparam int AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int SCW = $clog2(MAX_LEN + 1);

	st_t              st_q, st_d;
	logic [K_W-1:0]   parts_q;
	logic [TOT_W-1:0] total_q;
	logic [SCW-1:0]   count_q;
	logic             ovf_q;
	logic [TOT_W-1:0] i_q;
	logic [TOT_W-1:0] root_q;
	logic             phase_q;
	logic [TOT_W-1:0] cand_q;
	logic [SCW-1:0]   j_q;
	logic [SCW-1:0]   hits_q;
	logic [TOT_W-1:0] res_q;
	logic             res_ovf_q;

	logic             accept;
	logic             we;
	logic [AW-1:0]    addr;
	logic [TOT_W-1:0] rdata;
	logic [TOT_W-1:0] sum;
	logic             dgo, ddone;
	logic [TOT_W-1:0] ddend, ddvs, dquot, drem;
	logic [2*TOT_W-1:0] sq;
	logic             enough;

	assign accept = start && !busy;
	assign busy   = (st_q != ST_LOAD);
	assign sum    = total_q + TOT_W'(element);
	assign we     = accept && (count_q < SCW'(MAX_LEN));
	assign addr   = we ? count_q[AW-1:0] : j_q[AW-1:0];
	assign sq     = i_q * i_q;
	assign enough = 32'(hits_q) >= 32'(parts_q);

	mgkp_ram #(.WIDTH(TOT_W), .DEPTH(MAX_LEN)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(sum), .rdata(rdata)
	);

	mgkp_div u_div (
		.clk(clk), .arst_n(arst_n), .go(dgo), .dividend(ddend), .divisor(ddvs),
		.done(ddone), .quot(dquot), .rem(drem)
	);

	always_comb begin
		st_d  = st_q;
		dgo   = 1'b0;
		ddend = total_q;
		ddvs  = i_q;
		unique case (st_q)
			ST_LOAD: begin
				if (accept && last_element) begin
					st_d = (total_q == '0 && !we) || (we && sum == '0) ? ST_DONE : ST_NEXT;
				end
			end
			ST_NEXT: begin
				if (!phase_q && ({{TOT_W{1'b0}}, total_q} < sq)) begin
					st_d = ST_NEXT;
				end else if (phase_q && i_q == '0) begin
					st_d = ST_DONE;
				end else begin
					st_d = ST_DIVI;
				end
			end
			ST_DIVI: begin
				dgo  = 1'b1;
				st_d = ST_DIVI_WAIT;
			end
			ST_DIVI_WAIT: begin
				if (ddone) begin
					st_d = ST_CHK;
				end
			end
			ST_CHK: begin
				st_d = ST_NEXT;
				if (drem == '0 && !(phase_q && dquot == i_q)) begin
					st_d = ST_CNT_RD;
				end
			end
			ST_CNT_RD: begin
				if (j_q == count_q) begin
					st_d = enough ? ST_DONE : ST_NEXT;
				end else begin
					st_d = ST_CNT_DIV;
				end
			end
			ST_CNT_DIV: begin
				dgo   = 1'b1;
				ddend = rdata;
				ddvs  = cand_q;
				st_d  = ST_CNT_WAIT;
			end
			ST_CNT_WAIT: begin
				if (ddone) begin
					st_d = ST_CNT_ACC;
				end
			end
			ST_CNT_ACC: begin
				st_d = ST_CNT_RD;
			end
			ST_DONE: begin
				st_d = ST_LOAD;
			end
			default: st_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_LOAD;
			parts_q <= K_W'(1);
			total_q <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
			done    <= 1'b0;
			i_q     <= '0;
			root_q  <= '0;
			phase_q <= 1'b0;
			j_q     <= '0;
			hits_q  <= '0;
			res_q   <= TOT_W'(1);
		end else begin
			st_q <= st_d;
			done <= 1'b0;
			if (cfg_we) begin
				parts_q <= cfg_wdata;
			end
			unique case (st_q)
				ST_LOAD: begin
					if (accept) begin
						if (we) begin
							total_q <= sum;
							count_q <= count_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						i_q     <= '0;
						phase_q <= 1'b0;
						res_q   <= TOT_W'(1);
					end
				end
				ST_NEXT: begin
					if (!phase_q) begin
						if ({{TOT_W{1'b0}}, total_q} < sq || i_q == '1) begin
							phase_q <= 1'b1;
							i_q     <= root_q;
						end else begin
							i_q <= i_q + 1'b1;
							if (i_q != '0) begin
								root_q <= i_q;
							end
						end
						if (i_q == '0) begin
							root_q <= '0;
						end
					end
				end
				ST_CHK: begin
					cand_q <= phase_q ? i_q : dquot;
					j_q    <= '0;
					hits_q <= '0;
					if (phase_q) begin
						i_q <= i_q - 1'b1;
					end
				end
				ST_CNT_DIV: begin
					j_q <= j_q + 1'b1;
				end
				ST_CNT_ACC: begin
					if (drem == '0) begin
						hits_q <= hits_q + 1'b1;
					end
				end
				ST_CNT_RD: begin
					if (j_q == count_q && enough) begin
						res_q <= cand_q;
					end
				end
				ST_DONE: begin
					done    <= 1'b1;
					total_q <= '0;
					count_q <= '0;
					ovf_q   <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		res_ovf_q <= ovf_q;
	end

	assign best_divisor = res_q;
	assign overflowed   = (st_q == ST_LOAD) ? res_ovf_q : ovf_q;

	// Sequencing, bound and clearing checks.
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= SCW'(MAX_LEN)) else $error("store count past depth");
	a_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (count_q == '0 && total_q == '0)) else $error("not cleared");
endmodule
`default_nettype wire
